// ===== sv/rles_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rles_pkg
// Shared types, constants and tables of the RGB LED effect sequencer.
// ----------------------------------------------------------------------------
package rles_pkg;

    localparam int NUM_LEDS         = 4;
    localparam int LED_W            = 3 * NUM_LEDS;
    localparam int FADE_FRAME_TICKS = 15;

    localparam int TICK_W  = 16;
    localparam int PHASE_W = 5;
    localparam int REP_W   = 8;
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 3;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] CFG_BLINK_HALF  = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_ROTATE_STEP = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_BLINK_REP   = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_FADE_REP    = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_ROTATE_REP  = 3'd4;

    typedef enum logic [1:0] {
        EFF_SOLID  = 2'd0,
        EFF_BLINK  = 2'd1,
        EFF_FADE   = 2'd2,
        EFF_ROTATE = 2'd3
    } effect_t;

    // Decoded command character.
    typedef struct packed {
        logic       valid;
        logic       emerg;
        effect_t    effect;
        logic [2:0] colour;
    } cmd_t;

    // State that sets the LED drive.
    typedef struct packed {
        effect_t             effect;
        logic [2:0]          color_bits;
        logic [PHASE_W-1:0]  phase;
        logic [TICK_W-1:0]   tick;
    } drive_state_t;

    // Active-low red/green/blue bits of each colour number.
    function automatic logic [2:0] colour_bits(input logic [2:0] col);
        logic [2:0] bits;
        case (col)
            3'd1:    bits = 3'd6;
            3'd2:    bits = 3'd5;
            3'd3:    bits = 3'd3;
            3'd4:    bits = 3'd4;
            3'd5:    bits = 3'd2;
            3'd6:    bits = 3'd1;
            default: bits = 3'd0;
        endcase
        return bits;
    endfunction

    // LED lit in each rotation step: 0, 1, 3, 2.
    function automatic logic [1:0] rotate_led(input logic [1:0] step);
        logic [1:0] led;
        case (step)
            2'd0:    led = 2'd0;
            2'd1:    led = 2'd1;
            2'd2:    led = 2'd3;
            default: led = 2'd2;
        endcase
        return led;
    endfunction

endpackage
`default_nettype wire

// ===== sv/rles_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rles_decode
// Decodes a command character into kind, colour and effect.
// ----------------------------------------------------------------------------
module rles_decode (
    input  wire logic [rles_pkg::CHAR_W-1:0] char_code,
    output rles_pkg::cmd_t                   cmd
);
    import rles_pkg::*;

    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UZ   = 8'h5A;
    localparam logic [7:0] CH_UV   = 8'h56;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;
    localparam logic [7:0] CH_LV   = 8'h76;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_DOLR = 8'h24;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_AT   = 8'h40;

    logic [7:0] diff;
    logic [4:0] k;
    logic [4:0] base;
    logic [4:0] rem;
    logic       upper;
    logic       lower;

    assign upper = (char_code >= CH_UA) && (char_code <= CH_UZ) && (char_code != CH_UV);
    assign lower = (char_code >= CH_LA) && (char_code <= CH_LZ) && (char_code != CH_LV);
    assign diff  = upper ? (char_code - CH_UA) : (char_code - CH_LA);

    always_comb
    begin
        cmd = '0;
        k   = '0;
        if (upper || lower)
        begin
            cmd.valid = 1'b1;
            cmd.emerg = lower;
            k = (diff[4:0] > 5'd21) ? (diff[4:0] - 5'd1) : diff[4:0];
        end
        else
        begin
            case (char_code)
                CH_BANG: begin cmd.valid = 1'b1; k = 5'd25; end
                CH_HASH: begin cmd.valid = 1'b1; k = 5'd26; end
                CH_DOLR: begin cmd.valid = 1'b1; k = 5'd27; end
                CH_PCT:  begin cmd.valid = 1'b1; cmd.emerg = 1'b1; k = 5'd25; end
                CH_AMP:  begin cmd.valid = 1'b1; cmd.emerg = 1'b1; k = 5'd26; end
                CH_AT:   begin cmd.valid = 1'b1; cmd.emerg = 1'b1; k = 5'd27; end
                default: cmd.valid = 1'b0;
            endcase
        end
        // The effect is the group of seven the position falls in.
        if (k >= 5'd21)
        begin
            cmd.effect = EFF_ROTATE;
            base = 5'd21;
        end
        else if (k >= 5'd14)
        begin
            cmd.effect = EFF_FADE;
            base = 5'd14;
        end
        else if (k >= 5'd7)
        begin
            cmd.effect = EFF_BLINK;
            base = 5'd7;
        end
        else
        begin
            cmd.effect = EFF_SOLID;
            base = 5'd0;
        end
        rem = k - base;
        cmd.colour = (rem == 5'd6) ? 3'd0 : (rem[2:0] + 3'd1);
    end

endmodule
`default_nettype wire

// ===== sv/rles_drive.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rles_drive
// Forms the active-low LED drive word from the effect state.
// ----------------------------------------------------------------------------
module rles_drive (
    input  wire rles_pkg::drive_state_t     st,
    output logic [rles_pkg::LED_W-1:0]      led_drive
);
    import rles_pkg::*;

    logic [NUM_LEDS-1:0] lit_mask;
    logic [3:0]          duty;

    always_comb
    begin
        duty = st.phase[4] ? (4'd15 - st.phase[3:0]) : st.phase[3:0];
        case (st.effect)
            EFF_BLINK:  lit_mask = (st.phase == '0) ? '1 : '0;
            EFF_FADE:   lit_mask = (st.tick < {{(TICK_W-4){1'b0}}, duty}) ? '1 : '0;
            EFF_ROTATE: lit_mask = NUM_LEDS'(1) << rotate_led(st.phase[1:0]);
            default:    lit_mask = '1;
        endcase
    end

    for (genvar n = 0; n < NUM_LEDS; n++)
    begin : g_led
        assign led_drive[3*n +: 3] = lit_mask[n] ? st.color_bits : 3'b111;
    end

endmodule
`default_nettype wire

// ===== sv/rgb_led_effect_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The result for an item is registered and is on the master side in the cycle after its transfer.
// Throughput: one item per cycle; the single output register is refilled in the cycle
// it is taken, so a stall holds the slave side only while that register stays full.
// Reset (rst_n low, asynchronous): white solid setting, no emergency, no pending
// command, counters cleared, configuration at 100, 90, 15, 5 and 10.
// ----------------------------------------------------------------------------
// rgb_led_effect_sequencer_core
// Drives four active-low RGB LEDs from command characters and 1 ms ticks, with
// standing settings, one pending command slot and emergency runs.
// ----------------------------------------------------------------------------
module rgb_led_effect_sequencer_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Slave side. tdata: char_code[7:0]. tuser: command (0 tick, 1 character).
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          s_tuser,
    // Master side. tdata: led_drive[11:0], emergency_active[12], zeros[15:13].
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,
    // Configuration write port.
    input  wire logic                          cfg_we,
    input  wire logic [rles_pkg::ADDR_W-1:0]   cfg_addr,
    input  wire logic [rles_pkg::CFG_W-1:0]    cfg_wdata
);
    import rles_pkg::*;

    // Configuration registers.
    logic [TICK_W-1:0] blink_half_reg;
    logic [TICK_W-1:0] rotate_step_reg;
    logic [REP_W-1:0]  blink_rep_reg;
    logic [REP_W-1:0]  fade_rep_reg;
    logic [REP_W-1:0]  rotate_rep_reg;

    // Sequencer state and its next values.
    logic [2:0]          std_col_reg,   std_col_next;
    effect_t             std_eff_reg,   std_eff_next;
    logic [2:0]          act_bits_reg,  act_bits_next;
    effect_t             act_eff_reg,   act_eff_next;
    logic                emerg_reg,     emerg_next;
    logic [REP_W-1:0]    rep_reg,       rep_next;
    logic [PHASE_W-1:0]  phase_reg,     phase_next;
    logic [TICK_W-1:0]   tick_reg,      tick_next;
    logic [CHAR_W:0]     pend_reg,      pend_next;

    // Output stage.
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;

    logic                accept;
    cmd_t                in_cmd;
    cmd_t                pend_cmd;
    drive_state_t        drv_st;
    logic [LED_W-1:0]    led_now;
    logic [TICK_W-1:0]   phase_len;
    logic [PHASE_W:0]    phase_cnt;
    logic [TICK_W:0]     tick_sum;
    logic [PHASE_W-1:0]  phase_inc;
    logic                cycle_end;
    logic [REP_W-1:0]    run_len;

    // A new item is taken whenever the output register is empty or being emptied.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    rles_decode u_in_decode (
        .char_code (s_tdata),
        .cmd       (in_cmd)
    );

    rles_decode u_pend_decode (
        .char_code (pend_reg[CHAR_W-1:0]),
        .cmd       (pend_cmd)
    );

    // The result of every item shows the drive of the state before that item.
    assign drv_st = '{effect: act_eff_reg, color_bits: act_bits_reg,
                      phase: phase_reg, tick: tick_reg};

    rles_drive u_drive (
        .st        (drv_st),
        .led_drive (led_now)
    );

    // Length and number of phases of the active effect; zero registers act as one.
    always_comb
    begin
        case (act_eff_reg)
            EFF_BLINK:
            begin
                phase_len = (blink_half_reg == '0) ? TICK_W'(1) : blink_half_reg;
                phase_cnt = (PHASE_W+1)'(2);
            end
            EFF_FADE:
            begin
                phase_len = TICK_W'(FADE_FRAME_TICKS);
                phase_cnt = (PHASE_W+1)'(32);
            end
            EFF_ROTATE:
            begin
                phase_len = (rotate_step_reg == '0) ? TICK_W'(1) : rotate_step_reg;
                phase_cnt = (PHASE_W+1)'(4);
            end
            default:
            begin
                phase_len = TICK_W'(1);
                phase_cnt = (PHASE_W+1)'(1);
            end
        endcase
    end

    // Repeat count of an emergency run, taken from the pending command's effect.
    always_comb
    begin
        case (pend_cmd.effect)
            EFF_BLINK:  run_len = (blink_rep_reg  == '0) ? REP_W'(1) : blink_rep_reg;
            EFF_FADE:   run_len = (fade_rep_reg   == '0) ? REP_W'(1) : fade_rep_reg;
            EFF_ROTATE: run_len = (rotate_rep_reg == '0) ? REP_W'(1) : rotate_rep_reg;
            default:    run_len = REP_W'(1);
        endcase
    end

    assign tick_sum  = {1'b0, tick_reg} + (TICK_W+1)'(1);
    assign phase_inc = phase_reg + PHASE_W'(1);

    always_comb
    begin
        std_col_next  = std_col_reg;
        std_eff_next  = std_eff_reg;
        act_bits_next = act_bits_reg;
        act_eff_next  = act_eff_reg;
        emerg_next    = emerg_reg;
        rep_next      = rep_reg;
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        pend_next     = pend_reg;
        cycle_end     = 1'b0;

        if (accept)
        begin
            if (s_tuser)
            begin
                // Characters only fill the pending slot; time does not move.
                if (!emerg_reg && in_cmd.valid)
                begin
                    pend_next = {1'b1, s_tdata};
                end
            end
            else if (tick_sum >= {1'b0, phase_len})
            begin
                tick_next  = '0;
                phase_next = phase_inc;
                cycle_end  = ({1'b0, phase_inc} >= phase_cnt) || (phase_inc == '0);
            end
            else
            begin
                tick_next = tick_sum[TICK_W-1:0];
            end
        end

        if (cycle_end)
        begin
            // Count down an emergency run; it ends when the count reaches zero.
            if (emerg_reg)
            begin
                if (rep_reg != '0)
                begin
                    rep_next = rep_reg - REP_W'(1);
                end
                if (rep_next == '0)
                begin
                    emerg_next = 1'b0;
                end
            end
            // With no emergency left, the pending command is taken.
            if (!emerg_next && pend_reg[CHAR_W])
            begin
                if (pend_cmd.valid)
                begin
                    if (pend_cmd.emerg)
                    begin
                        act_bits_next = colour_bits(pend_cmd.colour);
                        act_eff_next  = pend_cmd.effect;
                        rep_next      = run_len;
                        emerg_next    = 1'b1;
                    end
                    else
                    begin
                        std_col_next = pend_cmd.colour;
                        std_eff_next = pend_cmd.effect;
                    end
                end
                pend_next = '0;
            end
            if (!emerg_next)
            begin
                act_bits_next = colour_bits(std_col_next);
                act_eff_next  = std_eff_next;
            end
            phase_next = '0;
            tick_next  = '0;
        end
    end

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_half_reg  <= TICK_W'(100);
            rotate_step_reg <= TICK_W'(90);
            blink_rep_reg   <= REP_W'(15);
            fade_rep_reg    <= REP_W'(5);
            rotate_rep_reg  <= REP_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BLINK_HALF:  blink_half_reg  <= cfg_wdata;
                CFG_ROTATE_STEP: rotate_step_reg <= cfg_wdata;
                CFG_BLINK_REP:   blink_rep_reg   <= cfg_wdata[REP_W-1:0];
                CFG_FADE_REP:    fade_rep_reg    <= cfg_wdata[REP_W-1:0];
                CFG_ROTATE_REP:  rotate_rep_reg  <= cfg_wdata[REP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_col_reg  <= '0;
            std_eff_reg  <= EFF_SOLID;
            act_bits_reg <= '0;
            act_eff_reg  <= EFF_SOLID;
            emerg_reg    <= 1'b0;
            rep_reg      <= '0;
            phase_reg    <= '0;
            tick_reg     <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            std_col_reg  <= std_col_next;
            std_eff_reg  <= std_eff_next;
            act_bits_reg <= act_bits_next;
            act_eff_reg  <= act_eff_next;
            emerg_reg    <= emerg_next;
            rep_reg      <= rep_next;
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            pend_reg     <= pend_next;
        end
    end

    // Output register: loaded on every transfer in, emptied by a transfer out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {3'b000, emerg_reg, led_now};
        end
    end

    // Outside an emergency run the repeat counter has run down to zero.
    a_rep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !emerg_reg |-> (rep_reg == '0))
        else $error("repeat count left over outside an emergency run");

    // Starting an emergency consumes the pending slot, and none is taken during one.
    a_no_pend_in_emerg: assert property (@(posedge clk) disable iff (!rst_n)
        emerg_reg |-> !pend_reg[CHAR_W])
        else $error("command pending during an emergency run");

    // The solid effect has a single phase.
    a_solid_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (act_eff_reg == EFF_SOLID) |-> (phase_reg == '0))
        else $error("phase index moved during the solid effect");

    // Every transfer in leaves a result waiting on the master side.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid_reg)
        else $error("accepted item produced no result");

endmodule
`default_nettype wire
